// File: hw/rtl/ackchk_pkg.sv
`default_nettype none

package ackchk_pkg;

  // Largest answer length kept; longer requests saturate here.
  localparam logic [8:0] MAX_ANSWER_BYTES = 9'd258;

  localparam logic [7:0] ACK_NORMAL  = 8'h5A;
  localparam logic [7:0] ACK_SPECIAL = 8'hA5;
  localparam logic [7:0] OP_INIT     = 8'hA8;
  localparam logic [7:0] OP_QUIT     = 8'h6A;

  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd2;
  localparam logic [7:0] DELAY_LIMIT_RESET = 8'd16;

  typedef enum logic [1:0] {
    REG_RETRY_LIMIT = 2'd0,
    REG_DELAY_LIMIT = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_LINK    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_BYTE    = 3'd0,
    EV_OK      = 3'd1,
    EV_RETRY   = 3'd2,
    EV_PROTO   = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_LINK    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ACK  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

endpackage

`default_nettype wire

// File: hw/rtl/ack_checksum_response_checker_top.sv
`default_nettype none

// Host-side response checker for a command/response serial link. Each request
// on the slave stream is a start (opcode, answer length, checksum width), a
// received byte, a receive timeout or a link error, selected by s_axis_tuser.
// After a start the block expects one acknowledge byte (0xA5 for the init and
// quit opcodes, 0x5A otherwise), then forwards every answer byte with its
// position and checks an additive 8-bit sum, or a 16-bit little-endian sum
// against the last two bytes. The last answer byte carries the verdict instead
// of a plain byte event. A bad ack, bad checksum or timeout reports a retry,
// bumps the attempt count and grows the pacing delay up to delay_limit; once
// retry_limit retries are used it reports failure. A link error fails at once.
// Rate: one request per clock cycle. Each request is decoded in a single pass
// and its result, if any, appears on the master stream in the cycle after it is
// accepted, held in one output register; s_axis_tready drops only while that
// register holds a result the sink has not taken. Requests that produce no
// result (starts, traffic while idle, accepted ack bytes ahead of answer data) are still consumed.
// The configuration port is always ready and should be written while idle.
module ack_checksum_response_checker_top
  import ackchk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] cmd_opcode, [16:8] answer_len, [17] crc_two, [25:18] rx_byte, rest zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] byte_value, [16:8] byte_index, [24:17] pace_delay, [28:25] attempts_used
  output logic [31:0]      m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]       m_axis_tuser
);

  // Configuration registers.
  logic [3:0] retry_limit;
  logic [7:0] delay_limit;

  // Transfer state.
  phase_t      phase, phase_next;
  logic        expect_nak, expect_nak_next;
  logic        wide_sum, wide_sum_next;
  logic [8:0]  answer_total, answer_total_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] received_check, received_check_next;
  logic [3:0]  retries_done, retries_done_next;
  logic [7:0]  delay_count, delay_count_next;

  // Result register.
  logic        out_valid;
  event_t      out_event;
  logic [7:0]  out_value;
  logic [8:0]  out_index;
  logic [7:0]  out_delay;
  logic [3:0]  out_attempts;

  // Request fields.
  kind_t       in_kind;
  logic [7:0]  in_opcode;
  logic [8:0]  in_len;
  logic        in_crc_two;
  logic [7:0]  in_byte;
  logic        s_fire;

  // Decode results.
  logic        have;
  event_t      ev;
  logic [7:0]  res_value;
  logic [8:0]  res_index;
  logic        verdict_bad;
  event_t      bad_code;
  logic        busy;
  logic [7:0]  ack_want;
  logic [9:0]  check_pos;
  logic [8:0]  count_inc;
  logic        sum_ok;

  assign in_kind    = kind_t'(s_axis_tuser);
  assign in_opcode  = s_axis_tdata[7:0];
  assign in_len     = s_axis_tdata[16:8];
  assign in_crc_two = s_axis_tdata[17];
  assign in_byte    = s_axis_tdata[25:18];

  // Take a new request whenever the result register is free or being drained.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_event;
  assign m_axis_tdata  = {3'b000, out_attempts, out_delay, out_index, out_value};

  assign busy      = (phase == PH_ACK) || (phase == PH_DATA);
  assign ack_want  = expect_nak ? ACK_SPECIAL : ACK_NORMAL;
  // Check bytes start at answer_total minus the checksum size.
  assign check_pos = {1'b0, byte_count} + (wide_sum ? 10'd2 : 10'd1);
  assign count_inc = byte_count + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
      delay_limit <= DELAY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        REG_DELAY_LIMIT: delay_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    expect_nak_next     = expect_nak;
    wide_sum_next       = wide_sum;
    answer_total_next   = answer_total;
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    received_check_next = received_check;
    retries_done_next   = retries_done;
    delay_count_next    = delay_count;
    have        = 1'b0;
    ev          = EV_BYTE;
    res_value   = 8'd0;
    res_index   = 9'd0;
    verdict_bad = 1'b0;
    bad_code    = EV_PROTO;
    sum_ok      = 1'b0;

    if (in_kind == KIND_START) begin
      // A start drops any running transfer.
      expect_nak_next     = (in_opcode == OP_INIT) || (in_opcode == OP_QUIT);
      wide_sum_next       = in_crc_two;
      answer_total_next   = (in_len > MAX_ANSWER_BYTES) ? MAX_ANSWER_BYTES : in_len;
      retries_done_next   = 4'd0;
      byte_count_next     = 9'd0;
      running_sum_next    = 16'd0;
      received_check_next = 16'd0;
      phase_next          = PH_ACK;
    end else if (busy) begin
      case (in_kind)
        KIND_LINK: begin
          phase_next = PH_IDLE;
          have       = 1'b1;
          ev         = EV_LINK;
        end
        KIND_TIMEOUT: begin
          have        = 1'b1;
          verdict_bad = 1'b1;
          bad_code    = EV_TIMEOUT;
        end
        default: begin
          if (phase == PH_ACK) begin
            if (in_byte != ack_want) begin
              have        = 1'b1;
              verdict_bad = 1'b1;
            end else if (answer_total == 9'd0) begin
              phase_next = PH_IDLE;
              have       = 1'b1;
              ev         = EV_OK;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            res_index = byte_count;
            res_value = in_byte;
            if (check_pos >= {1'b0, answer_total}) begin
              // Check bytes shift in from the top, low byte first.
              received_check_next = wide_sum ? {in_byte, received_check[15:8]}
                                             : {8'h00, in_byte};
            end else begin
              running_sum_next = running_sum + {8'h00, in_byte};
            end
            byte_count_next = count_inc;
            have            = 1'b1;
            if (count_inc >= answer_total) begin
              sum_ok = wide_sum ? (running_sum_next == received_check_next)
                                : (running_sum_next[7:0] == received_check_next[7:0]);
              if (sum_ok) begin
                phase_next = PH_IDLE;
                ev         = EV_OK;
              end else begin
                verdict_bad = 1'b1;
              end
            end
          end
        end
      endcase
    end

    if (verdict_bad) begin
      if (retries_done >= retry_limit) begin
        phase_next = PH_IDLE;
        ev         = bad_code;
      end else begin
        // Retry: count it, slow down, and wait for a fresh ack.
        retries_done_next   = retries_done + 4'd1;
        delay_count_next    = (delay_count < delay_limit) ? delay_count + 8'd1 : delay_count;
        phase_next          = PH_ACK;
        byte_count_next     = 9'd0;
        running_sum_next    = 16'd0;
        received_check_next = 16'd0;
        ev                  = EV_RETRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      expect_nak     <= 1'b0;
      wide_sum       <= 1'b0;
      answer_total   <= 9'd0;
      byte_count     <= 9'd0;
      running_sum    <= 16'd0;
      received_check <= 16'd0;
      retries_done   <= 4'd0;
      delay_count    <= 8'd0;
    end else if (s_fire) begin
      phase          <= phase_next;
      expect_nak     <= expect_nak_next;
      wide_sum       <= wide_sum_next;
      answer_total   <= answer_total_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
      received_check <= received_check_next;
      retries_done   <= retries_done_next;
      delay_count    <= delay_count_next;
    end
  end

  // Result register: load on a request that yields a result, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire && have) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && have) begin
      out_event    <= ev;
      out_value    <= res_value;
      out_index    <= res_index;
      out_delay    <= delay_count_next;
      out_attempts <= retries_done_next;
    end
  end

  // A start always arms the ack phase.
  assert property (@(posedge clk) disable iff (rst)
    s_fire && (in_kind == KIND_START) |=> phase == PH_ACK)
    else $error("start request did not enter the ack phase");

  // A link error during a transfer reports link fail on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_fire && (in_kind == KIND_LINK) && ((phase == PH_ACK) || (phase == PH_DATA))
    |=> m_axis_tvalid && (m_axis_tuser == EV_LINK) && (phase == PH_IDLE))
    else $error("link error not reported as link fail");

  // The pacing delay only grows outside reset.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> delay_count >= $past(delay_count))
    else $error("pacing delay decreased");

  // The byte position never passes the answer length.
  assert property (@(posedge clk) disable iff (rst)
    byte_count <= answer_total)
    else $error("byte count ran past the answer length");

endmodule

`default_nettype wire
